// ----- rtl/core/caft_pkg.sv -----
// Shared constants, codes and handshake structs of the CAN acceptance filter table.
package caft_pkg;

  localparam int TABLE_WORDS = 512;
  localparam int ADDR_W      = $clog2(TABLE_WORDS);
  localparam int PTR_W       = ADDR_W + 1;
  localparam int BND_W       = 12;
  localparam int CMP_W       = 16;
  localparam logic [CMP_W-1:0] LIMIT = CMP_W'(4 * TABLE_WORDS);

  localparam logic [31:0] STD_MASK = 32'hc7ffc7ff;
  localparam logic [31:0] EXT_MASK = 32'hc7ffffff;

  // Result status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_BAD_TYPE = 2'd2;
  localparam logic [1:0] ST_NOW_FULL = 2'd3;

  // Filter type codes.
  localparam logic [2:0] FT_FULLMSG = 3'd1;
  localparam logic [2:0] FT_STD     = 3'd2;
  localparam logic [2:0] FT_STD_GRP = 3'd3;
  localparam logic [2:0] FT_EXT     = 3'd4;
  localparam logic [2:0] FT_EXT_GRP = 3'd5;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear;
    logic load;
    logic rd_issue;
    logic sc_rd;
    logic sc_adv;
    logic set_pos;
    logic sh_rd;
    logic sh_wr;
    logic wr0;
    logic wr1;
    logic bump;
  } caft_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;
    logic err;
    logic scan_end;
    logic greater;
    logic shift_done;
    logic two_words;
  } caft_stat_t;

endpackage

// ----- rtl/core/caft_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module caft_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/core/caft_dp.sv -----
// Datapath: entry packing, boundary registers, scan and shift addressing, table RAM.
module caft_dp
  import caft_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  caft_cmd_t        cmd,
  output caft_stat_t       stat,
  input  logic             in_func,
  input  logic [2:0]       in_filter_type,
  input  logic [28:0]      in_id_first,
  input  logic [28:0]      in_id_second,
  input  logic             in_disable_first,
  input  logic             in_disable_second,
  input  logic [2:0]       in_controller_first,
  input  logic [2:0]       in_controller_second,
  input  logic [8:0]       in_word_index,
  output logic [1:0]       status,
  output logic [31:0]      read_word,
  output logic [BND_W-1:0] std_start,
  output logic [BND_W-1:0] std_group_start,
  output logic [BND_W-1:0] ext_start,
  output logic [BND_W-1:0] ext_group_start,
  output logic [BND_W-1:0] table_end
);

  logic [BND_W-1:0] ss_r, sgs_r, es_r, egs_r, te_r;
  logic [ADDR_W-1:0] clr_cnt_r;
  logic [31:0] entry_r, entry2_r;
  logic [2:0] ftype_r;
  logic is_read_r, rd_ok_r;
  logic [1:0] err_code_r;
  logic err_r;
  logic [BND_W-1:0] b_r, hi_r;
  logic [PTR_W-1:0] pos_r, i_r;
  logic [31:0] rdata, mask;
  logic ram_we, ram_re;
  logic [ADDR_W-1:0] waddr, raddr;
  logic [31:0] wdata;
  logic [CMP_W-1:0] room_chk, full_chk;
  logic [31:0] std_word, ext_word;
  logic [BND_W-1:0] lo_sel, hi_sel;
  logic [PTR_W-1:0] sh_dst;

  // Capacity tests: fill plus reserved full-message buffer room.
  assign room_chk = CMP_W'(te_r) + CMP_W'(4) + CMP_W'(ss_r) * CMP_W'(6);
  assign full_chk = CMP_W'(te_r) + CMP_W'(ss_r) * CMP_W'(6);

  // Entry packing for standard and extended words.
  assign std_word = {in_controller_first, in_disable_first, 1'b0, in_id_first[10:0],
                     in_controller_second, in_disable_second, 1'b0, in_id_second[10:0]};
  assign ext_word = {in_controller_first, in_id_first[28] | in_disable_first,
                     in_id_first[27:0]};

  // Section range of the incoming type.
  always_comb begin
    lo_sel = '0;
    hi_sel = '0;
    unique case (in_filter_type)
      FT_FULLMSG: begin lo_sel = '0;    hi_sel = ss_r;  end
      FT_STD:     begin lo_sel = ss_r;  hi_sel = sgs_r; end
      FT_STD_GRP: begin lo_sel = sgs_r; hi_sel = es_r;  end
      FT_EXT:     begin lo_sel = es_r;  hi_sel = egs_r; end
      FT_EXT_GRP: begin lo_sel = egs_r; hi_sel = te_r;  end
      default:    begin lo_sel = '0;    hi_sel = '0;    end
    endcase
  end

  assign mask = (ftype_r >= FT_EXT) ? EXT_MASK : STD_MASK;
  assign sh_dst = i_r - PTR_W'(1) + (ftype_r == FT_EXT_GRP ? PTR_W'(2) : PTR_W'(1));

  // RAM port selection.
  always_comb begin
    ram_we = cmd.clear | cmd.sh_wr | cmd.wr0 | cmd.wr1;
    waddr  = clr_cnt_r;
    wdata  = '0;
    if (cmd.sh_wr) begin
      waddr = sh_dst[ADDR_W-1:0];
      wdata = rdata;
    end else if (cmd.wr0) begin
      waddr = pos_r[ADDR_W-1:0];
      wdata = entry_r;
    end else if (cmd.wr1) begin
      waddr = pos_r[ADDR_W-1:0] + ADDR_W'(1);
      wdata = entry2_r;
    end
    ram_re = cmd.rd_issue | cmd.sc_rd | cmd.sh_rd;
    raddr  = in_word_index[ADDR_W-1:0];
    if (cmd.sc_rd) begin
      raddr = b_r[ADDR_W+1:2];
    end else if (cmd.sh_rd) begin
      raddr = i_r[ADDR_W-1:0] - ADDR_W'(1);
    end
  end

  caft_ram #(.WIDTH(32), .DEPTH(TABLE_WORDS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (ram_re),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Boundaries and clear counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ss_r      <= '0;
      sgs_r     <= '0;
      es_r      <= '0;
      egs_r     <= '0;
      te_r      <= '0;
      clr_cnt_r <= '0;
    end else begin
      if (cmd.clear) begin
        clr_cnt_r <= clr_cnt_r + ADDR_W'(1);
      end
      if (cmd.bump) begin
        if (ftype_r == FT_FULLMSG) ss_r <= ss_r + BND_W'(4);
        if (ftype_r <= FT_STD) sgs_r <= sgs_r + BND_W'(4);
        if (ftype_r <= FT_STD_GRP) es_r <= es_r + BND_W'(4);
        if (ftype_r <= FT_EXT) egs_r <= egs_r + BND_W'(4);
        te_r <= te_r + (ftype_r == FT_EXT_GRP ? BND_W'(8) : BND_W'(4));
      end
    end
  end

  // Item capture, scan pointer and shift pointer.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      is_read_r  <= in_func;
      rd_ok_r    <= {1'b0, in_word_index} < PTR_W'(TABLE_WORDS);
      ftype_r    <= in_filter_type;
      entry_r    <= (in_filter_type >= FT_EXT) ? ext_word : std_word;
      entry2_r   <= {in_controller_second, in_id_second};
      b_r        <= lo_sel;
      hi_r       <= hi_sel;
      i_r        <= te_r[BND_W-1:2];
      if (room_chk > LIMIT - CMP_W'(1)) begin
        err_r      <= 1'b1;
        err_code_r <= ST_FULL;
      end else if (in_filter_type < FT_FULLMSG || in_filter_type > FT_EXT_GRP) begin
        err_r      <= 1'b1;
        err_code_r <= ST_BAD_TYPE;
      end else begin
        err_r      <= 1'b0;
        err_code_r <= ST_OK;
      end
    end
    if (cmd.sc_adv) begin
      b_r <= b_r + (ftype_r == FT_EXT_GRP ? BND_W'(8) : BND_W'(4));
    end
    if (cmd.set_pos) begin
      pos_r <= b_r[BND_W-1:2];
    end
    if (cmd.sh_wr) begin
      i_r <= i_r - PTR_W'(1);
    end
  end

  assign stat.clr_last   = (clr_cnt_r == ADDR_W'(TABLE_WORDS - 1));
  assign stat.err        = err_r;
  assign stat.scan_end   = (b_r >= hi_r) || (CMP_W'(b_r) >= LIMIT);
  assign stat.greater    = (entry_r & mask) < (rdata & mask);
  assign stat.shift_done = (i_r == pos_r);
  assign stat.two_words  = (ftype_r == FT_EXT_GRP);

  // Result fields.
  always_comb begin
    if (is_read_r) begin
      status = ST_OK;
    end else if (err_r) begin
      status = err_code_r;
    end else begin
      status = (full_chk > LIMIT) ? ST_NOW_FULL : ST_OK;
    end
  end

  assign read_word       = (is_read_r && rd_ok_r) ? rdata : '0;
  assign std_start       = ss_r;
  assign std_group_start = sgs_r;
  assign ext_start       = es_r;
  assign ext_group_start = egs_r;
  assign table_end       = te_r;

endmodule

// ----- rtl/core/caft_ctrl.sv -----
// Controller: sequences clearing, reads, sorted-place scan, word shift and insert.
module caft_ctrl
  import caft_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic       in_func,
  input  caft_stat_t stat,
  output caft_cmd_t  cmd,
  output logic       busy,
  output logic       out_strobe
);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_CHECK = 4'd2;
  localparam logic [3:0] S_SCAN  = 4'd3;
  localparam logic [3:0] S_SCMP  = 4'd4;
  localparam logic [3:0] S_SHIFT = 4'd5;
  localparam logic [3:0] S_SHW   = 4'd6;
  localparam logic [3:0] S_WR0   = 4'd7;
  localparam logic [3:0] S_WR1   = 4'd8;
  localparam logic [3:0] S_BUMP  = 4'd9;
  localparam logic [3:0] S_OUT   = 4'd10;

  logic [3:0] state_r, state_nxt;

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (stat.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          if (in_func) begin
            cmd.rd_issue = 1'b1;
            state_nxt    = S_OUT;
          end else begin
            state_nxt = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        state_nxt = stat.err ? S_OUT : S_SCAN;
      end
      S_SCAN: begin
        if (stat.scan_end) begin
          cmd.set_pos = 1'b1;
          state_nxt   = S_SHIFT;
        end else begin
          cmd.sc_rd = 1'b1;
          state_nxt = S_SCMP;
        end
      end
      S_SCMP: begin
        if (stat.greater) begin
          cmd.set_pos = 1'b1;
          state_nxt   = S_SHIFT;
        end else begin
          cmd.sc_adv = 1'b1;
          state_nxt  = S_SCAN;
        end
      end
      S_SHIFT: begin
        if (stat.shift_done) begin
          state_nxt = S_WR0;
        end else begin
          cmd.sh_rd = 1'b1;
          state_nxt = S_SHW;
        end
      end
      S_SHW: begin
        cmd.sh_wr = 1'b1;
        state_nxt = S_SHIFT;
      end
      S_WR0: begin
        cmd.wr0   = 1'b1;
        state_nxt = stat.two_words ? S_WR1 : S_BUMP;
      end
      S_WR1: begin
        cmd.wr1   = 1'b1;
        state_nxt = S_BUMP;
      end
      S_BUMP: begin
        cmd.bump  = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = (state_r == S_OUT);

endmodule

// ----- rtl/core/can_acceptance_filter_table_insert.sv -----
// Top level of the CAN acceptance filter table with sorted insert.
//
// Channel  Handshake                   Payload
// input    start, busy (accept: start & !busy)   in_func .. in_word_index
// result   out_strobe, one cycle, no stall       out_status .. out_table_end_out
//
// After reset the table RAM is cleared one word a cycle, all 512 words, with busy high.
// A read issues its RAM read when accepted and delivers the word in S_OUT. An insert
// passes S_CHECK, then S_SCAN and S_SCMP per entry scanned, S_SHIFT and S_SHW per word
// shifted, S_WR0 (and S_WR1 for an extended group), S_BUMP and S_OUT; scan and shift
// together cover at most the filled words. A rejected insert goes from S_CHECK to S_OUT.
// The result cannot be stalled; busy drops at the clock edge that ends the strobe cycle.
module can_acceptance_filter_table_insert
  import caft_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic             in_func,
  input  logic [2:0]       in_filter_type,
  input  logic [28:0]      in_id_first,
  input  logic [28:0]      in_id_second,
  input  logic             in_disable_first,
  input  logic             in_disable_second,
  input  logic [2:0]       in_controller_first,
  input  logic [2:0]       in_controller_second,
  input  logic [8:0]       in_word_index,
  output logic             out_strobe,
  output logic [1:0]       out_status,
  output logic [31:0]      out_read_word,
  output logic [BND_W-1:0] out_std_start_out,
  output logic [BND_W-1:0] out_std_group_start_out,
  output logic [BND_W-1:0] out_ext_start_out,
  output logic [BND_W-1:0] out_ext_group_start_out,
  output logic [BND_W-1:0] out_table_end_out
);

  caft_cmd_t  cmd;
  caft_stat_t stat;

  caft_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_func    (in_func),
    .stat       (stat),
    .cmd        (cmd),
    .busy       (busy),
    .out_strobe (out_strobe)
  );

  caft_dp u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .stat                 (stat),
    .in_func              (in_func),
    .in_filter_type       (in_filter_type),
    .in_id_first          (in_id_first),
    .in_id_second         (in_id_second),
    .in_disable_first     (in_disable_first),
    .in_disable_second    (in_disable_second),
    .in_controller_first  (in_controller_first),
    .in_controller_second (in_controller_second),
    .in_word_index        (in_word_index),
    .status               (out_status),
    .read_word            (out_read_word),
    .std_start            (out_std_start_out),
    .std_group_start      (out_std_group_start_out),
    .ext_start            (out_ext_start_out),
    .ext_group_start      (out_ext_group_start_out),
    .table_end            (out_table_end_out)
  );

  // A result only appears while an item is in progress.
  a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> busy) else $error("result strobe while idle");

  // The block is free again right after it delivers a result.
  a_strobe_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !busy) else $error("busy after result");

  // An accepted item keeps the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("not busy after accept");

  // Section boundaries stay in order.
  a_bounds_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_std_start_out <= out_std_group_start_out) &&
    (out_std_group_start_out <= out_ext_start_out) &&
    (out_ext_start_out <= out_ext_group_start_out) &&
    (out_ext_group_start_out <= out_table_end_out)) else $error("boundaries out of order");

endmodule
